>>> rtl/core/bfiq_pkg.sv
// Shared types and constants for the bloom filter insert/query core.
package bfiq_pkg;

  localparam int FB_W = 17;
  localparam int PC_W = 5;
  localparam int MAX_FILTER_BITS_DEF = 65536;
  localparam int MAX_PROBES_DEF = 16;
  localparam int DIV_STEPS = 64;
  localparam int DIV_CNT_W = 6;

  localparam logic [63:0] WIDE_BASIS = 64'hcbf29ce484222325;
  localparam logic [31:0] NARROW_BASIS = 32'h811c9dc5;
  localparam logic [63:0] ZERO_STRIDE = 64'h9e3779b97f4a7c15;
  localparam logic [FB_W-1:0] FB_RESET = 17'd1024;
  localparam logic [PC_W-1:0] PC_RESET = 5'd7;

  localparam logic REG_FILTER_BITS = 1'b0;
  localparam logic REG_PROBE_COUNT = 1'b1;

  localparam logic [1:0] DIV_SRC_H1 = 2'd0;
  localparam logic [1:0] DIV_SRC_H2 = 2'd1;
  localparam logic [1:0] DIV_SRC_ONES = 2'd2;

  localparam logic [1:0] SAVE_NONE = 2'd0;
  localparam logic [1:0] SAVE_H1 = 2'd1;
  localparam logic [1:0] SAVE_H2 = 2'd2;
  localparam logic [1:0] SAVE_WR = 2'd3;

  typedef struct packed {
    logic       take;
    logic       clr;
    logic       div_load;
    logic [1:0] div_src;
    logic       div_step;
    logic [1:0] save_sel;
    logic       probe_init;
    logic       probe_rd;
    logic       probe_chk;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic key_done;
    logic div_last;
    logic probe_last;
    logic out_free;
  } status_t;

endpackage

>>> rtl/core/bfiq_ram.sv
// Generic simple dual-port RAM with registered read.
module bfiq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/bfiq_ctrl.sv
// Controller state machine for the bloom filter core.
module bfiq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  bfiq_pkg::status_t sts,
  output bfiq_pkg::cmd_t   cmd
);
  import bfiq_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_LD1  = 4'd2;
  localparam logic [3:0] S_DV1  = 4'd3;
  localparam logic [3:0] S_LD2  = 4'd4;
  localparam logic [3:0] S_DV2  = 4'd5;
  localparam logic [3:0] S_LD3  = 4'd6;
  localparam logic [3:0] S_DV3  = 4'd7;
  localparam logic [3:0] S_FIX  = 4'd8;
  localparam logic [3:0] S_PRD  = 4'd9;
  localparam logic [3:0] S_PCHK = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd = '0;
    cmd.div_src = DIV_SRC_H1;
    cmd.save_sel = SAVE_NONE;
    state_next = state;
    case (state)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.take = 1'b1;
        if (sts.key_done) state_next = S_LD1;
      end
      S_LD1: begin
        cmd.div_load = 1'b1;
        cmd.div_src = DIV_SRC_H1;
        state_next = S_DV1;
      end
      S_DV1: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_LD2;
      end
      S_LD2: begin
        cmd.div_load = 1'b1;
        cmd.div_src = DIV_SRC_H2;
        cmd.save_sel = SAVE_H1;
        state_next = S_DV2;
      end
      S_DV2: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_LD3;
      end
      S_LD3: begin
        cmd.div_load = 1'b1;
        cmd.div_src = DIV_SRC_ONES;
        cmd.save_sel = SAVE_H2;
        state_next = S_DV3;
      end
      S_DV3: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_FIX;
      end
      S_FIX: begin
        cmd.save_sel = SAVE_WR;
        cmd.probe_init = 1'b1;
        state_next = S_PRD;
      end
      S_PRD: begin
        cmd.probe_rd = 1'b1;
        state_next = S_PCHK;
      end
      S_PCHK: begin
        cmd.probe_chk = 1'b1;
        state_next = sts.probe_last ? S_FIN : S_PRD;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/bfiq_dpath.sv
// Datapath: key hashing, serial remainder unit, probe walk, bit store and result register.
module bfiq_dpath #(
  parameter int MAX_FILTER_BITS = bfiq_pkg::MAX_FILTER_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  bfiq_pkg::cmd_t              cmd,
  output bfiq_pkg::status_t           sts,
  input  logic [bfiq_pkg::FB_W-1:0]   filter_bits,
  input  logic [bfiq_pkg::PC_W-1:0]   probe_count,
  input  logic                        in_valid,
  input  logic                        func,
  input  logic [7:0]                  key_byte,
  input  logic                        byte_valid,
  input  logic                        last_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        was_add,
  output logic                        maybe_present
);
  import bfiq_pkg::*;

  localparam int Depth = (MAX_FILTER_BITS + 7) / 8;
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int PW = AW + 3;

  logic [63:0] hash_wide;
  logic [31:0] hash_narrow;
  logic [63:0] h1;
  logic [63:0] h2;
  logic        is_query;
  logic [63:0] div_src;
  logic [FB_W:0] div_rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [FB_W-1:0] h1m;
  logic [FB_W-1:0] h2m;
  logic [FB_W-1:0] wrm;
  logic [FB_W-1:0] residue;
  logic [63:0] acc;
  logic [PC_W-1:0] pidx;
  logic        all_set;
  logic [AW-1:0] clr_addr;

  logic        accept;
  logic [63:0] wide_x;
  logic [63:0] wide_fold;
  logic [31:0] narrow_x;
  logic [31:0] narrow_fold;
  logic [63:0] wide_next;
  logic [31:0] narrow_next;
  logic [FB_W:0] fb_ext;
  logic [FB_W:0] div_t;
  logic [FB_W:0] div_red;
  logic [FB_W:0] wr_inc;
  logic [64:0] acc_sum;
  logic [FB_W:0] r1;
  logic [FB_W:0] r1c;
  logic [FB_W:0] r2;
  logic [PW-1:0] pos_ext;
  logic [AW-1:0] idx;
  logic [2:0]    bsel;
  logic [7:0]    mask;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  assign accept = in_valid & cmd.take;

  assign wide_x = hash_wide ^ {56'd0, key_byte};
  assign wide_fold = (wide_x << 40) + (wide_x << 8) + (wide_x << 7) + (wide_x << 5)
                   + (wide_x << 4) + (wide_x << 1) + wide_x;
  assign narrow_x = hash_narrow ^ {24'd0, key_byte};
  assign narrow_fold = (narrow_x << 24) + (narrow_x << 8) + (narrow_x << 7)
                     + (narrow_x << 4) + (narrow_x << 1) + narrow_x;
  assign wide_next = byte_valid ? wide_fold : hash_wide;
  assign narrow_next = byte_valid ? narrow_fold : hash_narrow;

  assign fb_ext = {1'b0, filter_bits};
  assign div_t = {div_rem[FB_W-1:0], div_src[63]};
  assign div_red = (div_t >= fb_ext) ? (div_t - fb_ext) : div_t;
  assign wr_inc = div_rem + 1'b1;

  assign acc_sum = {1'b0, acc} + {1'b0, h2};
  assign r1 = {1'b0, residue} + {1'b0, h2m};
  assign r1c = (r1 >= fb_ext) ? (r1 - fb_ext) : r1;
  always_comb begin
    if (!acc_sum[64]) begin
      r2 = r1c;
    end else if (r1c >= {1'b0, wrm}) begin
      r2 = r1c - {1'b0, wrm};
    end else begin
      r2 = r1c + fb_ext - {1'b0, wrm};
    end
  end

  assign pos_ext = PW'(residue);
  assign idx = pos_ext[PW-1:3];
  assign bsel = pos_ext[2:0];
  assign mask = 8'd1 << bsel;

  assign ram_we = cmd.clr | (cmd.probe_chk & ~is_query);
  assign ram_waddr = cmd.clr ? clr_addr : idx;
  assign ram_wdata = cmd.clr ? 8'd0 : (ram_rdata | mask);

  bfiq_ram #(
    .WIDTH(8),
    .DEPTH(Depth)
  ) u_store (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_wide <= WIDE_BASIS;
      hash_narrow <= NARROW_BASIS;
      clr_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        if (last_byte) begin
          hash_wide <= WIDE_BASIS;
          hash_narrow <= NARROW_BASIS;
        end else begin
          hash_wide <= wide_next;
          hash_narrow <= narrow_next;
        end
      end
      if (cmd.clr) clr_addr <= clr_addr + 1'b1;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      h1 <= wide_next;
      h2 <= (narrow_next == 32'd0) ? ZERO_STRIDE : {32'd0, narrow_next};
      is_query <= func;
    end
    if (cmd.div_load) begin
      div_rem <= '0;
      div_cnt <= '0;
      case (cmd.div_src)
        DIV_SRC_H1: div_src <= h1;
        DIV_SRC_H2: div_src <= h2;
        default:    div_src <= '1;
      endcase
    end else if (cmd.div_step) begin
      div_rem <= div_red;
      div_src <= div_src << 1;
      div_cnt <= div_cnt + 1'b1;
    end
    case (cmd.save_sel)
      SAVE_H1: h1m <= div_rem[FB_W-1:0];
      SAVE_H2: h2m <= div_rem[FB_W-1:0];
      SAVE_WR: wrm <= (wr_inc == fb_ext) ? '0 : wr_inc[FB_W-1:0];
      default: ;
    endcase
    if (cmd.probe_init) begin
      residue <= h1m;
      acc <= h1;
      pidx <= '0;
      all_set <= 1'b1;
    end else if (cmd.probe_chk) begin
      residue <= r2[FB_W-1:0];
      acc <= acc_sum[63:0];
      pidx <= pidx + 1'b1;
      if (is_query && !ram_rdata[bsel]) all_set <= 1'b0;
    end
    if (cmd.out_load) begin
      was_add <= ~is_query;
      maybe_present <= is_query & all_set;
    end
  end

  assign sts.clr_last = (clr_addr == AW'(Depth - 1));
  assign sts.key_done = accept & last_byte;
  assign sts.div_last = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign sts.probe_last = (pidx == (probe_count - 1'b1));
  assign sts.out_free = ~out_valid | ~out_stall;

endmodule

>>> rtl/core/bloom_filter_insert_query_core.sv
// Top level of the bloom filter insert/query core.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | func, key_byte, byte_valid, last_byte
//  out     | output    | out_valid/out_stall| was_add, maybe_present
//  cfg     | input     | APB psel/penable   | filter_bits (0x0), probe_count (0x4)
//
// A key byte that is not last is folded into the hashes with no stall. The last
// item of a key runs three 64-step serial remainders, then a read state and a
// check state per probe on the bit store's read and write port.
// After reset every byte of the bit store is cleared in turn, with in_stall high.
// A finished result waits in the output register while out_stall is high.
module bloom_filter_insert_query_core #(
  parameter int MAX_FILTER_BITS = bfiq_pkg::MAX_FILTER_BITS_DEF,
  parameter int MAX_PROBES = bfiq_pkg::MAX_PROBES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [7:0]  key_byte,
  input  logic        byte_valid,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        was_add,
  output logic        maybe_present,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bfiq_pkg::*;

  cmd_t cmd;
  status_t sts;
  logic [FB_W-1:0] filter_bits;
  logic [PC_W-1:0] probe_count;
  logic            cfg_we;
  logic [FB_W-1:0] fb_wr;
  logic [PC_W-1:0] pc_wr;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;
  assign in_stall = ~cmd.take;

  always_comb begin
    fb_wr = pwdata[FB_W-1:0];
    if (fb_wr < FB_W'(8)) begin
      fb_wr = FB_W'(8);
    end else if (32'(pwdata[FB_W-1:0]) > 32'(MAX_FILTER_BITS)) begin
      fb_wr = FB_W'(MAX_FILTER_BITS);
    end
    pc_wr = pwdata[PC_W-1:0];
    if (pc_wr == '0) begin
      pc_wr = PC_W'(1);
    end else if (32'(pwdata[PC_W-1:0]) > 32'(MAX_PROBES)) begin
      pc_wr = PC_W'(MAX_PROBES);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_bits <= FB_RESET;
      probe_count <= PC_RESET;
    end else if (cfg_we) begin
      if (paddr[2] == REG_FILTER_BITS) begin
        filter_bits <= fb_wr;
      end else begin
        probe_count <= pc_wr;
      end
    end
  end

  assign prdata = (paddr[2] == REG_PROBE_COUNT) ? {27'd0, probe_count}
                                                : {15'd0, filter_bits};

  bfiq_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .sts(sts),
    .cmd(cmd)
  );

  bfiq_dpath #(
    .MAX_FILTER_BITS(MAX_FILTER_BITS)
  ) u_dpath (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .sts(sts),
    .filter_bits(filter_bits),
    .probe_count(probe_count),
    .in_valid(in_valid),
    .func(func),
    .key_byte(key_byte),
    .byte_valid(byte_valid),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .was_add(was_add),
    .maybe_present(maybe_present)
  );

`ifndef ASSERT_OFF
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.take, cmd.clr, cmd.div_load, cmd.div_step, cmd.probe_rd,
              cmd.probe_chk, cmd.out_load}))
    else $error("more than one datapath command active");
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("result load did not raise out_valid");
  a_clear_stall: assert property (@(posedge clk)
    $past(rst) |-> in_stall)
    else $error("input taken during bit store clear");
`endif

endmodule
